### src/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS       = 64;
  localparam int HEADER_BYTES     = 32;
  localparam int PREAMBLE_BYTES   = 64;
  localparam int REGION_BYTES_MAX = 65536;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int OFF_W = 17;

  localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] PRE_OFF = OFF_W'(PREAMBLE_BYTES);
  localparam logic [OFF_W-1:0] MIN_REGION = OFF_W'(PREAMBLE_BYTES + HEADER_BYTES);
  localparam logic [OFF_W-1:0] REGION_MAX = OFF_W'(REGION_BYTES_MAX);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic       REG_BASE   = 1'b0;
  localparam logic       REG_REGION = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [16:0]      request_length;
    logic [12:0]      alignment;
    logic [31:0]      address;
  } ffba_in_t;

  typedef struct packed {
    logic [31:0]      address_out;
    logic [1:0]       status;
  } ffba_out_t;

  typedef struct packed {
    logic [OFF_W-1:0] hdr;
    logic [OFF_W-1:0] len;
    logic             used;
  } ffba_entry_t;

  typedef struct packed {
    logic load;
    logic latch;
    logic latch_nxt;
    logic inc_idx;
    logic rd_next;
    logic rem_start;
    logic gap_latch;
    logic plan_alloc;
    logic plan_free;
    logic shift_step;
    logic wr_step;
    logic commit;
    logic fail;
  } ffba_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic used;
    logic contains;
    logic has_next;
    logic kind;
    logic rem_done;
    logic fit;
    logic shift_idle;
    logic wr_last;
  } ffba_sts_t;

endpackage
`default_nettype wire

### src/ffba_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_rem
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module ffba_rem import ffba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [12:0] divisor,
  output logic             done,
  output logic [12:0]      rem
);

  logic [31:0] dvd_r;
  logic [12:0] d_r;
  logic [12:0] r_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [13:0] t;
  logic [13:0] t_sub;

  assign t     = {r_r, dvd_r[31]};
  assign t_sub = t - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        d_r   <= divisor;
        r_r   <= '0;
        cnt_r <= 6'd32;
        run_r <= 1'b1;
      end else if (run_r) begin
        r_r   <= (t >= {1'b0, d_r}) ? t_sub[12:0] : t[12:0];
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule
`default_nettype wire

### src/ffba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_datapath
// block table memory, scan index, split and merge arithmetic, shift engine
// ----------------------------------------------------------------------------
module ffba_datapath import ffba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire ffba_in_t    in_data,
  input  wire ffba_cmd_t   cmd,
  output ffba_sts_t        sts,
  output ffba_out_t        out_data
);

  ffba_entry_t mem [MAX_BLOCKS];
  ffba_entry_t mem_q_r;
  logic        rd0_r;

  logic [31:0]      base_r;
  logic [OFF_W-1:0] region_r;
  logic [CNT_W-1:0] cnt_r;
  logic             stale_r;
  ffba_in_t         req_r;
  logic [12:0]      al_r;
  logic [CNT_W-1:0] idx_r;
  ffba_entry_t      ent_r, prv_r, nxt_r;
  logic [12:0]      gap_r;
  ffba_entry_t      w_r [3];
  logic [1:0]       wcnt_r, wi_r;
  logic [IDX_W-1:0] wadr_r;
  logic [CNT_W-1:0] cnt_new_r;
  ffba_out_t        res_r;
  logic [CNT_W-1:0] sp_r, stop_r;
  logic [1:0]       sh_r;
  logic             up_r;
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_a_r;

  ffba_entry_t      init_ent, rdata;
  logic [OFF_W-1:0] region_new;
  logic [IDX_W-1:0] ra;
  logic             we;
  logic [IDX_W-1:0] wa;
  ffba_entry_t      wd;
  logic             more;
  logic             rem_done;
  logic [12:0]      rem;
  logic [31:0]      off, d32, rd_absd;
  logic [OFF_W-1:0] rd_data;

  // alloc plan
  logic [OFF_W-1:0] data_e, avail, start_o, gap17, req17;
  logic [OFF_W:0]   req_h;
  logic             gs, ts, fit;
  logic [CNT_W-1:0] cnt1;
  logic [1:0]       n_ins;
  ffba_entry_t      a_w0, a_w1, a_tail;

  // free plan
  logic             pf, nf;
  ffba_entry_t      f_m;
  logic [CNT_W-1:0] f_wa;
  logic [1:0]       f_s;

  assign init_ent.hdr  = PRE_OFF;
  assign init_ent.len  = region_r - MIN_REGION;
  assign init_ent.used = 1'b0;
  assign rdata = rd0_r ? init_ent : mem_q_r;

  assign region_new = (cfg_wdata[16:0] > REGION_MAX) ? REGION_MAX : cfg_wdata[16:0];

  // shift engine
  assign more = up_r ? (sp_r != stop_r) : (sp_r < cnt_r);

  always_comb begin
    if (cmd.rd_next) begin
      ra = IDX_W'(idx_r + CNT_W'(1));
    end else if (cmd.shift_step && more) begin
      ra = sp_r[IDX_W-1:0];
    end else begin
      ra = idx_r[IDX_W-1:0];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = pend_a_r;
    wd = rdata;
    if (pend_v_r) begin
      we = 1'b1;
    end else if (cmd.wr_step) begin
      we = 1'b1;
      wa = wadr_r + IDX_W'(wi_r);
      wd = w_r[wi_r];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q_r <= mem[ra];
  end

  // containment test for free, alignment remainder for alloc
  assign rd_data = rdata.hdr + HDR_OFF;
  assign d32     = {15'd0, rd_data};
  assign off     = req_r.address - base_r;
  assign rd_absd = base_r + {15'd0, rd_data};

  ffba_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (rd_absd),
    .divisor  (al_r),
    .done     (rem_done),
    .rem      (rem)
  );

  always_comb begin
    gap17   = {4'd0, gap_r};
    req17   = req_r.request_length;
    data_e  = ent_r.hdr + HDR_OFF;
    avail   = ent_r.len - gap17;
    fit     = (gap17 <= ent_r.len) && (avail >= req17);
    gs      = (gap17 > HDR_OFF) && (cnt_r < CNT_MAX);
    cnt1    = cnt_r + CNT_W'(gs);
    req_h   = {1'b0, req17} + {1'b0, HDR_OFF};
    ts      = ({1'b0, avail} > req_h) && (cnt1 < CNT_MAX);
    start_o = data_e + gap17;
    n_ins   = {1'b0, gs} + {1'b0, ts};
    a_tail.hdr  = start_o + req17;
    a_tail.len  = avail - req17 - HDR_OFF;
    a_tail.used = 1'b0;
    if (gs) begin
      a_w0.hdr  = ent_r.hdr;
      a_w0.len  = gap17 - HDR_OFF;
      a_w0.used = 1'b0;
      a_w1.hdr  = start_o - HDR_OFF;
      a_w1.len  = ts ? req17 : avail;
      a_w1.used = 1'b1;
    end else begin
      a_w0.hdr  = ent_r.hdr;
      a_w0.len  = ts ? (gap17 + req17) : ent_r.len;
      a_w0.used = 1'b1;
      a_w1      = a_tail;
    end
  end

  always_comb begin
    pf = !prv_r.used;
    nf = sts.has_next && !nxt_r.used;
    f_m.used = 1'b0;
    if (pf && nf) begin
      f_m.hdr = prv_r.hdr;
      f_m.len = prv_r.len + ent_r.len + nxt_r.len + HDR_OFF + HDR_OFF;
      f_wa    = idx_r - CNT_W'(1);
      f_s     = 2'd2;
    end else if (pf) begin
      f_m.hdr = prv_r.hdr;
      f_m.len = prv_r.len + ent_r.len + HDR_OFF;
      f_wa    = idx_r - CNT_W'(1);
      f_s     = 2'd1;
    end else if (nf) begin
      f_m.hdr = ent_r.hdr;
      f_m.len = ent_r.len + nxt_r.len + HDR_OFF;
      f_wa    = idx_r;
      f_s     = 2'd1;
    end else begin
      f_m.hdr = ent_r.hdr;
      f_m.len = ent_r.len;
      f_wa    = idx_r;
      f_s     = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      region_r <= REGION_MAX;
      cnt_r    <= CNT_W'(1);
      stale_r  <= 1'b1;
      pend_v_r <= 1'b0;
      rd0_r    <= 1'b0;
    end else begin
      rd0_r    <= stale_r && (ra == '0);
      pend_v_r <= cmd.shift_step && more;
      if (we && wa == '0) begin
        stale_r <= 1'b0;
      end
      if (cfg_we) begin
        stale_r <= 1'b1;
        if (cfg_index == REG_BASE) begin
          base_r <= cfg_wdata;
          cnt_r  <= CNT_W'(region_r >= MIN_REGION);
        end else begin
          region_r <= region_new;
          cnt_r    <= CNT_W'(region_new >= MIN_REGION);
        end
      end else if (cmd.commit) begin
        cnt_r <= cnt_new_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_data;
      al_r         <= (in_data.alignment == '0) ? 13'd1 : in_data.alignment;
      idx_r        <= '0;
      ent_r.used   <= 1'b1;
    end
    if (cmd.latch) begin
      prv_r <= ent_r;
      ent_r <= rdata;
    end
    if (cmd.latch_nxt) begin
      nxt_r <= rdata;
    end
    if (cmd.inc_idx) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.gap_latch) begin
      gap_r <= (rem == '0) ? 13'd0 : (al_r - rem);
    end
    if (cmd.fail) begin
      res_r.address_out <= '0;
      res_r.status      <= (req_r.kind == KIND_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
    end
    if (cmd.plan_alloc) begin
      w_r[0]    <= a_w0;
      w_r[1]    <= a_w1;
      w_r[2]    <= a_tail;
      wcnt_r    <= n_ins + 2'd1;
      wi_r      <= '0;
      wadr_r    <= idx_r[IDX_W-1:0];
      cnt_new_r <= cnt_r + CNT_W'(n_ins);
      up_r      <= 1'b1;
      sh_r      <= n_ins;
      stop_r    <= idx_r;
      sp_r      <= (n_ins == 2'd0) ? idx_r : (cnt_r - CNT_W'(1));
      res_r.address_out <= base_r + {15'd0, start_o};
      res_r.status      <= ST_OK;
    end
    if (cmd.plan_free) begin
      w_r[0]    <= f_m;
      wcnt_r    <= 2'd1;
      wi_r      <= '0;
      wadr_r    <= f_wa[IDX_W-1:0];
      cnt_new_r <= cnt_r - CNT_W'(f_s);
      up_r      <= 1'b0;
      sh_r      <= f_s;
      sp_r      <= (f_s == 2'd0) ? cnt_r : (f_wa + CNT_W'(1) + CNT_W'(f_s));
      res_r.address_out <= '0;
      res_r.status      <= ST_OK;
    end
    if (cmd.shift_step && more) begin
      sp_r     <= up_r ? (sp_r - CNT_W'(1)) : (sp_r + CNT_W'(1));
      pend_a_r <= up_r ? IDX_W'(sp_r + CNT_W'(sh_r)) : IDX_W'(sp_r - CNT_W'(sh_r));
    end
    if (cmd.wr_step) begin
      wi_r <= wi_r + 2'd1;
    end
  end

  assign sts.idx_end    = idx_r >= cnt_r;
  assign sts.used       = rdata.used;
  assign sts.contains   = (off >= d32) && ((off - d32) < {15'd0, rdata.len});
  assign sts.has_next   = (idx_r + CNT_W'(1)) < cnt_r;
  assign sts.kind       = req_r.kind;
  assign sts.rem_done   = rem_done;
  assign sts.fit        = fit;
  assign sts.shift_idle = !more && !pend_v_r;
  assign sts.wr_last    = wi_r == (wcnt_r - 2'd1);

  assign out_data = res_r;

endmodule
`default_nettype wire

### src/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// request sequencer: table scan, fit check, shift and write-back
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire ffba_sts_t sts,
  output ffba_cmd_t      cmd,
  output logic           busy,
  output logic           out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_DIV, S_CHK, S_NXT, S_FPLAN, S_SHIFT, S_WRITE, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.idx_end) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        cmd.latch = 1'b1;
        if (sts.kind == KIND_ALLOC) begin
          if (sts.used) begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_RD;
          end else begin
            cmd.rem_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else if (sts.used && sts.contains) begin
          if (sts.has_next) begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_NXT;
          end else begin
            state_nxt = S_FPLAN;
          end
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_DIV: begin
        if (sts.rem_done) begin
          cmd.gap_latch = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.fit) begin
          cmd.plan_alloc = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_NXT: begin
        cmd.latch_nxt = 1'b1;
        state_nxt     = S_FPLAN;
      end
      S_FPLAN: begin
        cmd.plan_free = 1'b1;
        state_nxt     = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_idle) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.wr_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;

endmodule
`default_nettype wire

### src/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// first-fit allocator over an address-ordered block table with coalescing
// ----------------------------------------------------------------------------
// flow: each entry is read (S_RD), evaluated (S_EV); a free block tested for fit runs
//   the 32-step serial remainder (S_DIV) and a fit check (S_CHK); a hit then
//   shifts moved entries, does 1 to 3 writes (free: plan, shift, 1 write), then S_DONE
// requests: one request at a time, start is taken only while busy is low
// results: one out_valid pulse per request, a miss ends when the scan passes the last entry
// reset: synchronous active low, table holds one free block spanning region
module first_fit_block_allocator_top import ffba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire ffba_in_t    in_data,
  output logic             out_valid,
  output ffba_out_t        out_data
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ffba_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### test/first_fit_block_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top_tb
// self-checking bench for the first-fit block allocator: directed requests
// then random allocate/free traffic over several region settings, each
// result compared with its typed value or a behavioural copy of the table
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top_tb;
  import ffba_pkg::*;

  localparam int WATCHDOG_CYCLES = 40000;

  typedef struct {
    logic      kind;
    int        length;
    int        align;
    logic [31:0] addr;
    bit        typed;
    logic [31:0] want_addr;
    logic [1:0]  want_status;
  } row_t;

  typedef struct {
    logic [31:0] addr;
    int unsigned len;
  } grant_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_index = REG_BASE;
  logic [31:0] cfg_wdata = '0;
  logic      start = 1'b0;
  logic      busy;
  ffba_in_t  in_data = '0;
  logic      out_valid;
  ffba_out_t out_data;

  int unsigned blk_hdr [MAX_BLOCKS];
  int unsigned blk_len [MAX_BLOCKS];
  bit          blk_used [MAX_BLOCKS];
  int unsigned blk_count;
  int unsigned region_base;
  int unsigned region_size;

  ffba_out_t pending_results[$];
  grant_t    live_grants[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        sender_idle_pct = 0;

  first_fit_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic void table_rebuild();
    int unsigned r;
    r = (region_size > REGION_BYTES_MAX) ? REGION_BYTES_MAX : region_size;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_hdr[k] = 0; blk_len[k] = 0; blk_used[k] = 0;
    end
    if (r < PREAMBLE_BYTES + HEADER_BYTES) begin
      blk_count = 0;
    end else begin
      blk_count = 1;
      blk_hdr[0] = PREAMBLE_BYTES;
      blk_len[0] = r - PREAMBLE_BYTES - HEADER_BYTES;
    end
  endfunction

  function automatic void table_open(int unsigned pos, int unsigned hdr, int unsigned len);
    for (int unsigned k = blk_count; k > pos; k--) begin
      blk_hdr[k] = blk_hdr[k-1]; blk_len[k] = blk_len[k-1]; blk_used[k] = blk_used[k-1];
    end
    blk_hdr[pos] = hdr; blk_len[pos] = len; blk_used[pos] = 0;
    blk_count++;
  endfunction

  function automatic void table_close(int unsigned pos);
    for (int unsigned k = pos; k + 1 < blk_count; k++) begin
      blk_hdr[k] = blk_hdr[k+1]; blk_len[k] = blk_len[k+1]; blk_used[k] = blk_used[k+1];
    end
    blk_count--;
  endfunction

  function automatic ffba_out_t allocator_outcome(ffba_in_t req);
    ffba_out_t   res;
    int unsigned al, want, data, avail, rem, gap, fin, first, cur, off, d;
    bit          pf, nf;
    res.address_out = '0;
    if (req.kind == KIND_ALLOC) begin
      res.status = ST_NO_SPACE;
      al = (req.alignment == 0) ? 1 : req.alignment;
      want = req.request_length;
      for (int unsigned i = 0; i < blk_count; i++) begin
        if (blk_used[i]) continue;
        data = blk_hdr[i] + HEADER_BYTES;
        avail = blk_len[i];
        rem = (region_base + data) % al;
        gap = rem ? al - rem : 0;
        if (gap > avail) continue;
        avail -= gap;
        if (avail < want) continue;
        fin = data + blk_len[i];
        first = data + gap;
        cur = i;
        if (gap > HEADER_BYTES && blk_count < MAX_BLOCKS) begin
          blk_len[i] = gap - HEADER_BYTES;
          table_open(i + 1, first - HEADER_BYTES, 0);
          cur = i + 1;
        end
        if (avail > want + HEADER_BYTES && blk_count < MAX_BLOCKS) begin
          table_open(cur + 1, first + want, avail - want - HEADER_BYTES);
          blk_len[cur] = first + want - (blk_hdr[cur] + HEADER_BYTES);
        end else begin
          blk_len[cur] = fin - (blk_hdr[cur] + HEADER_BYTES);
        end
        blk_used[cur] = 1;
        res.address_out = region_base + first;
        res.status = ST_OK;
        break;
      end
    end else begin
      res.status = ST_NOT_FOUND;
      off = req.address - region_base;
      for (int unsigned i = 0; i < blk_count; i++) begin
        if (!blk_used[i]) continue;
        d = blk_hdr[i] + HEADER_BYTES;
        if (off < d || off - d >= blk_len[i]) continue;
        pf = i > 0 && !blk_used[i-1];
        nf = i + 1 < blk_count && !blk_used[i+1];
        if (pf && nf) begin
          blk_len[i-1] += blk_len[i] + blk_len[i+1] + 2 * HEADER_BYTES;
          table_close(i + 1);
          table_close(i);
        end else if (pf) begin
          blk_len[i-1] += blk_len[i] + HEADER_BYTES;
          table_close(i);
        end else if (nf) begin
          blk_len[i] += blk_len[i+1] + HEADER_BYTES;
          blk_used[i] = 0;
          table_close(i + 1);
        end else begin
          blk_used[i] = 0;
        end
        res.status = ST_OK;
        break;
      end
    end
    return res;
  endfunction

  // result checking and watchdog, sampled away from the driving edge
  always @(negedge clk) begin
    ffba_out_t exp_res;
    if (rst_n) begin
      if (out_valid || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result actual %h/%0d", $time,
                   out_data.address_out, out_data.status);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_data.address_out !== exp_res.address_out)
            begin
            $display("%0t: address_out expected %h actual %h", $time,
                     exp_res.address_out, out_data.address_out);
            errors++;
          end
          if (out_data.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, out_data.status);
            errors++;
          end
        end
      end
      if (quiet_cycles > WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic issue_request(ffba_in_t req, bit typed, ffba_out_t typed_res);
    ffba_out_t res;
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 12) : 0;
    repeat (gap) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    in_data <= req;
    do @(negedge clk); while (busy);
    @(posedge clk);
    start <= 1'b0;
    res = allocator_outcome(req);
    pending_results.push_back(typed ? typed_res : res);
    if (req.kind == KIND_ALLOC && res.status == ST_OK && req.request_length != 0)
      live_grants.push_back('{res.address_out, req.request_length});
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE) region_base = value;
    else region_size = value & 32'h1FFFF;
    table_rebuild();
    live_grants.delete();
  endtask

  task automatic random_traffic(int count, int max_len);
    ffba_in_t req;
    int pick, sel;
    for (int n = 0; n < count; n++) begin
      req = '0;
      pick = $urandom_range(99);
      if (pick < 55) begin
        req.kind = KIND_ALLOC;
        req.request_length = ($urandom_range(19) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(0, max_len);
        sel = $urandom_range(9);
        req.alignment = (sel < 6) ? (13'd1 << $urandom_range(0, 6)) :
                        (sel < 8) ? $urandom_range(0, 8191) : $urandom_range(1, 100);
        req.address = $urandom;
      end else begin
        req.kind = KIND_FREE;
        req.request_length = $urandom_range(0, 131071);
        req.alignment = $urandom_range(0, 8191);
        if (pick < 92 && live_grants.size() != 0) begin
          sel = $urandom_range(0, live_grants.size() - 1);
          req.address = live_grants[sel].addr + $urandom_range(0, live_grants[sel].len - 1);
          live_grants.delete(sel);
        end else begin
          req.address = (pick < 96) ? region_base + $urandom_range(0, 70000) : $urandom;
        end
      end
      issue_request(req, 1'b0, '0);
    end
  endtask

  initial begin
    row_t      rows[$];
    ffba_in_t  req;
    ffba_out_t typed_res;

    region_base = 0;
    region_size = REGION_BYTES_MAX;
    table_rebuild();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests from reset: base 0, full region
    rows = '{
      '{KIND_ALLOC, 16,     1,    0,            1, 32'd96,  ST_OK},
      '{KIND_ALLOC, 8,      0,    0,            1, 32'd144, ST_OK},
      '{KIND_ALLOC, 65536,  1,    0,            1, 32'd0,   ST_NO_SPACE},
      '{KIND_ALLOC, 131071, 8191, 0,            1, 32'd0,   ST_NO_SPACE},
      '{KIND_FREE,  0,      0,    0,            1, 32'd0,   ST_NOT_FOUND},
      '{KIND_FREE,  131071, 8191, 32'hFFFFFFFF, 1, 32'd0,   ST_NOT_FOUND},
      '{KIND_ALLOC, 0,      1,    0,            0, 0, 0},
      '{KIND_ALLOC, 100,    4096, 0,            0, 0, 0},
      '{KIND_ALLOC, 40,     8191, 0,            0, 0, 0},
      '{KIND_ALLOC, 32,     64,   0,            0, 0, 0},
      '{KIND_FREE,  0,      1,    32'd100,      1, 32'd0,   ST_OK},
      '{KIND_FREE,  0,      1,    32'd100,      1, 32'd0,   ST_NOT_FOUND},
      '{KIND_FREE,  0,      1,    32'd150,      0, 0, 0},
      '{KIND_FREE,  0,      1,    32'd4096,     0, 0, 0},
      '{KIND_ALLOC, 4000,   128,  0,            0, 0, 0},
      '{KIND_ALLOC, 60000,  1,    0,            0, 0, 0},
      '{KIND_ALLOC, 1,      3,    0,            0, 0, 0},
      '{KIND_FREE,  0,      0,    32'd4224,     0, 0, 0}
    };
    foreach (rows[r]) begin
      req.kind = rows[r].kind;
      req.request_length = rows[r].length;
      req.alignment = rows[r].align;
      req.address = rows[r].addr;
      typed_res.address_out = rows[r].want_addr;
      typed_res.status = rows[r].want_status;
      issue_request(req, rows[r].typed, typed_res);
    end

    // region too small, then exactly one empty block
    write_register(REG_REGION, 32'd95);
    rows = '{
      '{KIND_ALLOC, 0, 1, 0,     1, 32'd0, ST_NO_SPACE},
      '{KIND_FREE,  0, 1, 32'd96, 1, 32'd0, ST_NOT_FOUND}
    };
    foreach (rows[r]) begin
      req = '0;
      req.kind = rows[r].kind;
      req.request_length = rows[r].length;
      req.alignment = rows[r].align;
      req.address = rows[r].addr;
      typed_res.address_out = rows[r].want_addr;
      typed_res.status = rows[r].want_status;
      issue_request(req, 1'b1, typed_res);
    end
    write_register(REG_REGION, 32'd96);
    req = '0;
    req.kind = KIND_ALLOC;
    req.alignment = 13'd1;
    issue_request(req, 1'b1, '{32'd96, ST_OK});
    issue_request(req, 1'b1, '{32'd0, ST_NO_SPACE});

    // random phases over several settings and sender idling
    write_register(REG_REGION, 32'h1FFFF);
    sender_idle_pct = 0;
    random_traffic(100, 900);
    write_register(REG_BASE, 32'hFFFFFFF0);
    sender_idle_pct = 75;
    random_traffic(90, 1500);
    write_register(REG_REGION, $urandom_range(200, 8000));
    sender_idle_pct = 14;
    random_traffic(80, 300);
    write_register(REG_BASE, $urandom);
    write_register(REG_REGION, 32'd65536);
    sender_idle_pct = 50;
    random_traffic(90, 2000);
    write_register(REG_BASE, 32'd0);
    sender_idle_pct = 0;
    random_traffic(80, 200);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
src/ffba_pkg.sv
src/ffba_rem.sv
src/ffba_datapath.sv
src/ffba_ctrl.sv
src/first_fit_block_allocator_top.sv
test/first_fit_block_allocator_top_tb.sv
